FILE: src/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the byte-serial SHA-256.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned WinDepth = 16;
  localparam int unsigned Rounds  = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

FILE: src/sha256_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per cycle: schedule word update and a..h step.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic [31:0] vars_in  [8],
  input  logic [31:0] win      [16],
  input  logic [5:0]  t,
  output logic [31:0] vars_out [8],
  output logic [31:0] wt
);

  logic [3:0]  i0, i1, i9, i14;
  logic [31:0] w15, w2, s0, s1, big0, big1, ch, maj, t1, t2;

  always_comb begin
    i0  = t[3:0];
    i1  = t[3:0] + 4'd1;
    i9  = t[3:0] + 4'd9;
    i14 = t[3:0] + 4'd14;
    w15 = win[i1];
    w2  = win[i14];
    s0  = sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3);
    s1  = sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10);
    if (t < 6'd16) begin
      wt = win[i0];
    end else begin
      wt = win[i0] + s0 + win[i9] + s1;
    end
    big1 = sha256_pkg::ror(vars_in[4], 6) ^ sha256_pkg::ror(vars_in[4], 11)
         ^ sha256_pkg::ror(vars_in[4], 25);
    ch   = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
    t1   = vars_in[7] + big1 + ch + sha256_pkg::round_k(t) + wt;
    big0 = sha256_pkg::ror(vars_in[0], 2) ^ sha256_pkg::ror(vars_in[0], 13)
         ^ sha256_pkg::ror(vars_in[0], 22);
    maj  = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
         ^ (vars_in[1] & vars_in[2]);
    t2   = big0 + maj;
    vars_out[7] = vars_in[6];
    vars_out[6] = vars_in[5];
    vars_out[5] = vars_in[4];
    vars_out[4] = vars_in[3] + t1;
    vars_out[3] = vars_in[2];
    vars_out[2] = vars_in[1];
    vars_out[1] = vars_in[0];
    vars_out[0] = t1 + t2;
  end

endmodule

FILE: src/sha256_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-serial SHA-256 with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// A byte that neither fills a block nor ends the message keeps in_ready high.
// The 64th byte of a block starts a compression: a load step, 64 rounds on
// the shared round unit, a fold into the hash. An end marker adds one
// padding byte per cycle plus one or two compressions, then 8 output words.
// Reset loads the initial hash, clears the bit count and fill; no clear pass.
module sha256_message_digest (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::in_item_t   in_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  output sha256_pkg::out_item_t  out_data,
  output logic                   out_valid,
  input  logic                   out_ready
);

  sha256_pkg::state_t state, state_next;

  logic [31:0] hash [8];
  logic [31:0] win  [16];
  logic [31:0] vars [8];
  logic [31:0] vars_rnd [8];
  logic [31:0] wt;
  logic [63:0] bit_count, len;
  logic [5:0]  fill;
  logic [5:0]  t;
  logic [3:0]  pad_cnt;
  logic        pad_mode, len_phase;
  logic        msg_end;
  logic [2:0]  oidx;

  logic        put;
  logic [7:0]  put_byte;
  logic        acc;

  sha256_round u_round (
    .vars_in  (vars),
    .win      (win),
    .t        (t),
    .vars_out (vars_rnd),
    .wt       (wt)
  );

  assign acc       = in_valid && in_ready;
  assign in_ready  = (state == sha256_pkg::ST_IDLE);
  assign out_valid = (state == sha256_pkg::ST_EMIT);
  assign out_data.digest_word = hash[oidx];
  assign out_data.word_index  = oidx;
  assign out_data.last_word   = (oidx == 3'd7);

  // byte source: input bytes while idle, padding and length bytes in ST_PAD
  always_comb begin
    put      = 1'b0;
    put_byte = 8'h00;
    if (state == sha256_pkg::ST_IDLE) begin
      put      = acc && in_data.byte_valid;
      put_byte = in_data.data_byte;
    end else if (state == sha256_pkg::ST_PAD) begin
      put = 1'b1;
      if (len_phase) begin
        put_byte = len[63 - {pad_cnt[2:0], 3'b000} -: 8];
      end else if (!pad_mode) begin
        put_byte = 8'h80;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_data.byte_valid && fill == 6'd63) begin
            state_next = sha256_pkg::ST_LOAD;
          end else if (in_data.message_end) begin
            state_next = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_LOAD:  state_next = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (t == 6'd63) state_next = sha256_pkg::ST_FINAL;
      sha256_pkg::ST_FINAL: begin
        if (len_phase && pad_cnt == 4'd8) begin
          state_next = sha256_pkg::ST_EMIT;
        end else if (msg_end) begin
          state_next = sha256_pkg::ST_PAD;
        end else begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_PAD: begin
        if (fill == 6'd63) begin
          state_next = sha256_pkg::ST_LOAD;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_ready && oidx == 3'd7) state_next = sha256_pkg::ST_IDLE;
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::init_hash(3'(i));
      bit_count <= '0;
      fill      <= '0;
      t         <= '0;
      pad_cnt   <= '0;
      pad_mode  <= 1'b0;
      len_phase <= 1'b0;
      msg_end   <= 1'b0;
      oidx      <= '0;
    end else begin
      if (put) begin
        if (fill[1:0] == 2'd0) begin
          win[fill[5:2]] <= {put_byte, 24'h0};
        end else begin
          win[fill[5:2]] <= win[fill[5:2]]
                          | ({24'h0, put_byte} << ({3'd0, ~fill[1:0]} * 5'd8));
        end
        fill <= fill + 6'd1;
      end
      if (state == sha256_pkg::ST_IDLE && acc) begin
        if (in_data.byte_valid) begin
          bit_count <= bit_count + 64'd8;
          len       <= bit_count + 64'd8;
        end else begin
          len <= bit_count;
        end
        pad_mode  <= 1'b0;
        len_phase <= 1'b0;
        pad_cnt   <= '0;
        msg_end   <= in_data.message_end;
      end
      if (state == sha256_pkg::ST_PAD) begin
        pad_mode <= 1'b1;
        if (len_phase) begin
          pad_cnt <= pad_cnt + 4'd1;
        end else if (fill == 6'd55) begin
          len_phase <= 1'b1;
        end
      end
      if (state == sha256_pkg::ST_LOAD) begin
        vars <= hash;
        t    <= '0;
      end
      if (state == sha256_pkg::ST_ROUND) begin
        vars <= vars_rnd;
        if (t >= 6'd16) win[t[3:0]] <= wt;
        t <= t + 6'd1;
      end
      if (state == sha256_pkg::ST_FINAL) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + vars[i];
      end
      if (state == sha256_pkg::ST_EMIT && out_ready) begin
        oidx <= oidx + 3'd1;
        if (oidx == 3'd7) begin
          for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::init_hash(3'(i));
          bit_count <= '0;
          fill      <= '0;
          len_phase <= 1'b0;
          pad_mode  <= 1'b0;
          msg_end   <= 1'b0;
          pad_cnt   <= '0;
        end
      end
    end
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    state != sha256_pkg::ST_IDLE |-> !in_ready) else $error("ready while busy");
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    state == sha256_pkg::ST_LOAD |=> state == sha256_pkg::ST_ROUND && t == 6'd0)
    else $error("round start");
  a_emit_fill: assert property (@(posedge clk) disable iff (rst)
    state == sha256_pkg::ST_EMIT |-> fill == 6'd0) else $error("fill at emit");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_word |=> state == sha256_pkg::ST_IDLE)
    else $error("no return to idle");

endmodule
